### rtl/ghash_pkg.sv
// ghash package: beat types, op codes and the gf(2^128) multiply
package ghash_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;
    localparam int TOTAL_W = 61;
    localparam int COUNT_W = 5;

    localparam logic [1:0] OP_AAD    = 2'd0;
    localparam logic [1:0] OP_CT     = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [COUNT_W-1:0] BLOCK_BYTES = COUNT_W'(16);

    localparam logic [0:0] CFG_KEY_HI = 1'b0;
    localparam logic [0:0] CFG_KEY_LO = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic [HALF_W-1:0]  block_hi;
        logic [HALF_W-1:0]  block_lo;
        logic [COUNT_W-1:0] byte_count;
    } ghash_in_t;

    typedef struct packed {
        logic [HALF_W-1:0] tag_hi;
        logic [HALF_W-1:0] tag_lo;
    } ghash_out_t;

    // vector bit 127 holds the x^0 coefficient in gcm order
    function automatic logic [BLOCK_W-1:0] ghash_rev(input logic [BLOCK_W-1:0] v);
        logic [BLOCK_W-1:0] r;
        for (int i = 0; i < BLOCK_W; i++) begin
            r[i] = v[BLOCK_W-1-i];
        end
        return r;
    endfunction

    // carry-less product then two folds by x^128 = x^7 + x^2 + x + 1
    function automatic logic [BLOCK_W-1:0] ghash_gf_mul(input logic [BLOCK_W-1:0] a_vec,
                                                        input logic [BLOCK_W-1:0] h_vec);
        logic [BLOCK_W-1:0]   a;
        logic [BLOCK_W-1:0]   h;
        logic [2*BLOCK_W-2:0] c;
        logic [BLOCK_W+6:0]   t;
        logic [BLOCK_W-1:0]   low;
        logic [BLOCK_W-1:0]   e;
        logic [BLOCK_W-1:0]   f;
        a = ghash_rev(a_vec);
        h = ghash_rev(h_vec);
        c = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            c = c ^ (({{(BLOCK_W-1){1'b0}}, h} << i) & {(2*BLOCK_W-1){a[i]}});
        end
        t = {8'b0, c[2*BLOCK_W-2:BLOCK_W]};
        t = t ^ (t << 1) ^ (t << 2) ^ (t << 7);
        low = c[BLOCK_W-1:0] ^ t[BLOCK_W-1:0];
        e = {{(BLOCK_W-7){1'b0}}, t[BLOCK_W+6:BLOCK_W]};
        f = e ^ (e << 1) ^ (e << 2) ^ (e << 7);
        return ghash_rev(low ^ f);
    endfunction

endpackage

### rtl/ghash_authenticator_top.sv
// ghash authenticator: one gf(2^128) multiply per block beat, tag on finish
//
//  channel  direction  payload       handshake
//  in       sink       ghash_in_t    in_valid / in_ready
//  out      source     ghash_out_t   out_valid / out_ready
//  cfg      sink       64-bit key    cfg_we, cfg_index, cfg_data
//
// one block beat per cycle while no finish beat stalls; a beat is held in the input register, and
// the combinational multiply into the accumulator sets the rate
// a tag is valid on out after its finish beat is accepted, from the edge
// where that beat leaves the input register
// a finish beat stalls in the input register only while an untaken tag is held
// reset clears the accumulator, byte totals, key and all valid flags
module ghash_authenticator_top
    import ghash_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ghash_in_t         in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ghash_out_t        out_data,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [HALF_W-1:0] cfg_data
);

    logic [HALF_W-1:0]  key_hi_reg, key_lo_reg;
    logic               s1_valid_reg;
    ghash_in_t          s1_data_reg;
    logic [BLOCK_W-1:0] acc_reg, acc_next;
    logic [TOTAL_W-1:0] aad_total_reg, aad_total_next;
    logic [TOTAL_W-1:0] ct_total_reg, ct_total_next;
    logic               out_valid_reg, out_valid_next;
    ghash_out_t         out_data_reg, out_data_next;

    logic               is_finish;
    logic               is_block;
    logic               s1_fire;
    logic [COUNT_W-1:0] n_sat;
    logic [7:0]         pad_shift;
    logic [BLOCK_W-1:0] pad_mask;
    logic [BLOCK_W-1:0] absorb_word;
    logic [BLOCK_W-1:0] product;
    logic [TOTAL_W-1:0] n_ext;

    assign is_finish = (s1_data_reg.op == OP_FINISH);
    assign is_block  = ((s1_data_reg.op == OP_AAD) || (s1_data_reg.op == OP_CT))
                       && (s1_data_reg.byte_count != '0);
    assign s1_fire   = s1_valid_reg && (!is_finish || !out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_fire;

    // counts above a full block saturate
    assign n_sat     = (s1_data_reg.byte_count > BLOCK_BYTES) ? BLOCK_BYTES
                                                              : s1_data_reg.byte_count;
    assign pad_shift = {n_sat, 3'b000};
    assign pad_mask  = ~({BLOCK_W{1'b1}} >> pad_shift);
    assign n_ext     = {{(TOTAL_W-COUNT_W){1'b0}}, n_sat};

    always_comb
    begin
        if (is_finish) begin
            absorb_word = {aad_total_reg, 3'b000, ct_total_reg, 3'b000};
        end else begin
            absorb_word = {s1_data_reg.block_hi, s1_data_reg.block_lo} & pad_mask;
        end
    end

    assign product = ghash_gf_mul(acc_reg ^ absorb_word, {key_hi_reg, key_lo_reg});

    always_comb
    begin
        acc_next       = acc_reg;
        aad_total_next = aad_total_reg;
        ct_total_next  = ct_total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (s1_fire) begin
            if (is_finish) begin
                acc_next       = '0;
                aad_total_next = '0;
                ct_total_next  = '0;
                out_valid_next = 1'b1;
                out_data_next  = '{tag_hi: product[BLOCK_W-1:HALF_W],
                                   tag_lo: product[HALF_W-1:0]};
            end else if (is_block) begin
                acc_next = product;
                if (s1_data_reg.op == OP_AAD) begin
                    aad_total_next = aad_total_reg + n_ext;
                end else begin
                    ct_total_next = ct_total_reg + n_ext;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_hi_reg    <= '0;
            key_lo_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            aad_total_reg <= '0;
            ct_total_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_KEY_HI: key_hi_reg <= cfg_data;
                    CFG_KEY_LO: key_lo_reg <= cfg_data;
                    default:    key_lo_reg <= key_lo_reg;
                endcase
            end
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            acc_reg       <= acc_next;
            aad_total_reg <= aad_total_next;
            ct_total_reg  <= ct_total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            s1_data_reg <= in_data;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
